// File: design/lsa_pkg.sv
// Shared constants, types and saturating add for the label scatter accumulator.
package lsa_pkg;

  localparam int MAX_SEGMENTS = 1024;
  localparam int MAX_CHANNELS = 8;
  localparam int VALUE_W      = 16;
  localparam int SUM_W        = 32;
  localparam int LABEL_W      = 32;
  localparam int CHAN_W       = 3;

  localparam int SEG_IDX_W  = $clog2(MAX_SEGMENTS);
  localparam int ADDR_W     = SEG_IDX_W + CHAN_W;
  localparam int DEPTH      = MAX_SEGMENTS * MAX_CHANNELS;

  localparam int SEG_CNT_W  = 11;
  localparam int CH_CNT_W   = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = SEG_CNT_W;

  localparam logic [CFG_IDX_W-1:0] REG_SUPERPIXEL_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT    = CFG_IDX_W'(1);

  localparam logic OP_ACCUM = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [SEG_CNT_W-1:0] SEG_CNT_RST = SEG_CNT_W'(1024);
  localparam logic [CH_CNT_W-1:0]  CH_CNT_RST  = CH_CNT_W'(8);
  localparam logic [SEG_CNT_W-1:0] SEG_LIMIT   = SEG_CNT_W'(MAX_SEGMENTS);
  localparam logic [CH_CNT_W-1:0]  CH_LIMIT    = CH_CNT_W'(MAX_CHANNELS);

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [ADDR_W-1:0]         addr_t;

  typedef struct packed {
    logic [SEG_CNT_W-1:0] seg_limit;
    logic [CH_CNT_W-1:0]  chan_limit;
  } cfg_t;

  function automatic sum_t sat_add(input sum_t s, input value_t v);
    logic signed [SUM_W:0] wide;
    sum_t res;
    wide = {s[SUM_W-1], s} + {{(SUM_W+1-VALUE_W){v[VALUE_W-1]}}, v};
    if (wide[SUM_W] != wide[SUM_W-1]) begin
      res = wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      res = wide[SUM_W-1:0];
    end
    return res;
  endfunction

endpackage

// File: design/lsa_in_if.sv
// Input channel: accumulate or read-and-clear request word.
interface lsa_in_if import lsa_pkg::*;;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic signed [LABEL_W-1:0]   pixel_label;
  logic [CHAN_W-1:0]           channel;
  logic signed [VALUE_W-1:0]   grad_value;

  modport source(output valid, op, pixel_label, channel, grad_value, input ready);
  modport sink(input valid, op, pixel_label, channel, grad_value, output ready);
endinterface

// File: design/lsa_out_if.sv
// Result channel: read sum word.
interface lsa_out_if import lsa_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [SUM_W-1:0]   sum_value;
  logic                      entry_valid;

  modport source(output valid, sum_value, entry_valid, input ready);
  modport sink(input valid, sum_value, entry_valid, output ready);
endinterface

// File: design/lsa_cfg_if.sv
// Configuration write channel.
interface lsa_cfg_if import lsa_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_W-1:0]    index;
  logic [CFG_DATA_W-1:0]   data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: design/lsa_sum_ram.sv
// Simple dual-port RAM, one write port, one registered read port.
module lsa_sum_ram #(
  parameter int DEPTH_P = 8192,
  parameter int WIDTH_P = 32,
  parameter int AW_P    = $clog2(DEPTH_P)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW_P-1:0]    waddr,
  input  logic [WIDTH_P-1:0] wdata,
  input  logic               re,
  input  logic [AW_P-1:0]    raddr,
  output logic [WIDTH_P-1:0] rdata
);

  logic [WIDTH_P-1:0] mem [DEPTH_P];
  logic [WIDTH_P-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/lsa_cfg_regs.sv
// Configuration registers with clamped effective limits.
module lsa_cfg_regs import lsa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  lsa_cfg_if.sink    cfg_word,
  output cfg_t       cfg
);

  logic [SEG_CNT_W-1:0] superpixel_count_r;
  logic [CH_CNT_W-1:0]  channel_count_r;

  assign cfg_word.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      superpixel_count_r <= SEG_CNT_RST;
      channel_count_r    <= CH_CNT_RST;
    end else if (cfg_word.valid) begin
      case (cfg_word.index)
        REG_SUPERPIXEL_COUNT: superpixel_count_r <= cfg_word.data;
        REG_CHANNEL_COUNT:    channel_count_r    <= cfg_word.data[CH_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.seg_limit  = (superpixel_count_r > SEG_LIMIT) ? SEG_LIMIT : superpixel_count_r;
    cfg.chan_limit = (channel_count_r > CH_LIMIT) ? CH_LIMIT : channel_count_r;
  end

endmodule

// File: design/lsa_accum.sv
// Read-modify-write controller: lookup, saturating add, read-clear, forwarding, clear pass.
module lsa_accum import lsa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  lsa_in_if.sink     in_word,
  lsa_out_if.source  out_word,
  output logic       ram_we,
  output addr_t      ram_waddr,
  output sum_t       ram_wdata,
  output logic       ram_re,
  output addr_t      ram_raddr,
  input  sum_t       ram_rdata
);

  logic   clearing_r;
  addr_t  clr_addr_r;

  logic   s1_valid_r;
  logic   s1_op_r;
  logic   s1_ok_r;
  addr_t  s1_addr_r;
  value_t s1_grad_r;
  logic   fwd_hit_r;
  sum_t   fwd_data_r;

  logic   out_valid_r;
  sum_t   out_sum_r;
  logic   out_ok_r;

  logic   in_ok;
  addr_t  in_addr;
  logic   accept;
  logic   s1_go;
  logic   s1_we;
  sum_t   old_sum;
  sum_t   new_sum;

  always_comb begin
    in_ok   = !in_word.pixel_label[LABEL_W-1] &&
              (in_word.pixel_label[LABEL_W-2:0] < (LABEL_W-1)'(cfg.seg_limit)) &&
              ({1'b0, in_word.channel} < cfg.chan_limit);
    in_addr = {in_word.pixel_label[SEG_IDX_W-1:0], in_word.channel};
  end

  always_comb begin
    old_sum = fwd_hit_r ? fwd_data_r : ram_rdata;
    new_sum = (s1_op_r == OP_READ) ? '0 : sat_add(old_sum, s1_grad_r);
    s1_go   = s1_valid_r && ((s1_op_r != OP_READ) || !out_valid_r || out_word.ready);
    s1_we   = s1_go && s1_ok_r;
    in_word.ready = !clearing_r && (!s1_valid_r || s1_go);
    accept  = in_word.valid && in_word.ready;
  end

  always_comb begin
    ram_re    = accept;
    ram_raddr = in_addr;
    if (clearing_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_we;
      ram_waddr = s1_addr_r;
      ram_wdata = new_sum;
    end
  end

  // clear pass over the whole store after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == addr_t'(DEPTH - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r    <= in_word.op;
      s1_ok_r    <= in_ok;
      s1_addr_r  <= in_addr;
      s1_grad_r  <= in_word.grad_value;
      fwd_hit_r  <= s1_we && (s1_addr_r == in_addr);
      fwd_data_r <= new_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && (s1_op_r == OP_READ)) begin
      out_valid_r <= 1'b1;
    end else if (out_word.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && (s1_op_r == OP_READ)) begin
      out_sum_r <= s1_ok_r ? old_sum : '0;
      out_ok_r  <= s1_ok_r;
    end
  end

  assign out_word.valid       = out_valid_r;
  assign out_word.sum_value   = out_sum_r;
  assign out_word.entry_valid = out_ok_r;

endmodule

// File: design/label_scatter_accumulator_core.sv
// Read words pass from the lookup stage to the output register, which drives out_word.
// Throughput: one word per cycle while in_word.ready is high; the RAM read for each
// word is issued at accept and written back from the lookup stage, with forwarding
// between back-to-back hits. Accumulate words give no result; a full output register
// holds a read word in the lookup stage and the input waits behind it.
// Reset: counts go to 1024 segments and 8 channels, then a clear pass over all 8192
// entries zeroes the store while in_word.ready is low; config writes still land.
module label_scatter_accumulator_core import lsa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  lsa_in_if.sink     in_word,
  lsa_out_if.source  out_word,
  lsa_cfg_if.sink    cfg_word
);

  cfg_t  cfg;
  logic  ram_we;
  addr_t ram_waddr;
  sum_t  ram_wdata;
  logic  ram_re;
  addr_t ram_raddr;
  sum_t  ram_rdata;

  lsa_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_word (cfg_word),
    .cfg      (cfg)
  );

  lsa_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_word   (in_word),
    .out_word  (out_word),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  lsa_sum_ram #(
    .DEPTH_P (DEPTH),
    .WIDTH_P (SUM_W),
    .AW_P    (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// File: tb/lsa_sum_checker.sv
// Checker for the label scatter accumulator: predicts read words and compares them.
`timescale 1ns / 1ps
module lsa_sum_checker import lsa_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  lsa_in_if    in_mon,
  lsa_out_if   out_mon,
  lsa_cfg_if   cfg_mon,
  output int   fail_count,
  output int   pending_reads
);

  typedef struct packed {
    sum_t sum_value;
    logic entry_valid;
  } read_word_t;

  sum_t                 segment_total [DEPTH];
  logic [SEG_CNT_W-1:0] seg_count;
  logic [CH_CNT_W-1:0]  ch_count;
  read_word_t           read_queue [$];

  initial begin
    fail_count    = 0;
    pending_reads = 0;
  end

  function automatic sum_t add_clamped(input sum_t acc, input value_t v);
    longint total;
    total = longint'(acc) + longint'(v);
    if (total > longint'(SUM_MAX)) return SUM_MAX;
    if (total < longint'(SUM_MIN)) return SUM_MIN;
    return sum_t'(total);
  endfunction

  // true when label and channel address a live entry
  function automatic bit entry_slot(input logic signed [LABEL_W-1:0] label,
                                    input logic [CHAN_W-1:0] chan, output int slot);
    int segs;
    int chans;
    segs  = (int'(seg_count) > MAX_SEGMENTS) ? MAX_SEGMENTS : int'(seg_count);
    chans = (int'(ch_count) > MAX_CHANNELS) ? MAX_CHANNELS : int'(ch_count);
    slot  = 0;
    if (label < 0 || int'(label) >= segs || int'(chan) >= chans) return 1'b0;
    slot = int'(label) * MAX_CHANNELS + int'(chan);
    return slot < DEPTH;
  endfunction

  task automatic log_miss(input string what, input longint want, input longint got);
    if (fail_count < 10) begin
      $display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $time);
    end
    fail_count++;
  endtask

  always @(posedge clk) begin
    read_word_t want_w;
    int         slot;
    bit         hit;
    if (!rst_n) begin
      foreach (segment_total[k]) segment_total[k] = '0;
      seg_count = SEG_CNT_RST;
      ch_count  = CH_CNT_RST;
      read_queue.delete();
    end else begin
      // older read word leaves before a new request is taken
      if (out_mon.valid && out_mon.ready) begin
        if (read_queue.size() == 0) begin
          log_miss("unexpected read word, sum_value", 0, out_mon.sum_value);
        end else begin
          want_w = read_queue.pop_front();
          if (out_mon.sum_value !== want_w.sum_value) begin
            log_miss("sum_value", want_w.sum_value, out_mon.sum_value);
          end
          if (out_mon.entry_valid !== want_w.entry_valid) begin
            log_miss("entry_valid", want_w.entry_valid, out_mon.entry_valid);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        hit = entry_slot(in_mon.pixel_label, in_mon.channel, slot);
        if (in_mon.op == OP_ACCUM) begin
          if (hit) segment_total[slot] = add_clamped(segment_total[slot], in_mon.grad_value);
        end else begin
          if (hit) begin
            want_w = '{segment_total[slot], 1'b1};
            segment_total[slot] = '0;
          end else begin
            want_w = '{'0, 1'b0};
          end
          read_queue.push_back(want_w);
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_SUPERPIXEL_COUNT: seg_count = cfg_mon.data;
          REG_CHANNEL_COUNT:    ch_count  = cfg_mon.data[CH_CNT_W-1:0];
          default: ;
        endcase
      end
    end
    pending_reads <= read_queue.size();
  end

endmodule

// File: tb/tb.sv
// Testbench top: clock, reset, stimulus and verdict for the label scatter accumulator.
`timescale 1ns / 1ps
module tb;
  import lsa_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);
  localparam int PHASES         = 10;
  localparam int PHASE_WORDS    = 125;
  localparam int SQUEEZE_CYCLES = 300;
  localparam int SQUEEZE_PHASE  = 1;
  localparam int CALM_PHASE     = 6;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_reads;
  bit   tx_calm;
  bit   rx_calm;
  bit   squeeze_req;
  int   seg_eff;
  int   ch_eff;

  int seg_set [PHASES] = '{1024, 2047, 0, 1, 37, 1024, 1023, 1025, 3, 512};
  int ch_set  [PHASES] = '{8, 15, 8, 1, 3, 0, 7, 9, 15, 5};

  lsa_in_if  in_ch ();
  lsa_out_if out_ch ();
  lsa_cfg_if cfg_ch ();

  label_scatter_accumulator_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_ch),
    .out_word (out_ch),
    .cfg_word (cfg_ch)
  );

  lsa_sum_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .cfg_mon       (cfg_ch),
    .fail_count    (fail_count),
    .pending_reads (pending_reads)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_calm || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [LABEL_W-1:0] pick_label();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return LABEL_W'($urandom_range(0, 3));
    if (r < 65) return LABEL_W'(seg_eff - 1 + int'($urandom_range(0, 2)));
    if (r < 75) return LABEL_W'($urandom_range(0, 1023));
    if (r < 85) return LABEL_W'($urandom);
    if (r < 92) return LABEL_W'(-int'($urandom_range(1, 4)));
    return (r < 96) ? 32'sh7fff_ffff : 32'sh8000_0000;
  endfunction

  function automatic value_t pick_grad();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'sh7fff;
    if (r < 20) return 16'sh8000;
    return VALUE_W'($urandom);
  endfunction

  task automatic push_word(input logic op, input logic signed [LABEL_W-1:0] label,
                           input logic [CHAN_W-1:0] chan, input value_t grad);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid       <= 1'b0;
      in_ch.op          <= 1'($urandom);
      in_ch.pixel_label <= LABEL_W'($urandom);
      in_ch.channel     <= CHAN_W'($urandom);
      in_ch.grad_value  <= VALUE_W'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid       <= 1'b1;
    in_ch.op          <= op;
    in_ch.pixel_label <= label;
    in_ch.channel     <= chan;
    in_ch.grad_value  <= grad;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic end_burst();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // accumulate words leave no trace, so idle on past the last pending read as well
  task automatic drain();
    while (pending_reads != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_counts(input int segs, input int chans);
    write_reg(REG_SUPERPIXEL_COUNT, CFG_DATA_W'(segs));
    // upper data bits are don't-care for the channel count
    write_reg(REG_CHANNEL_COUNT, CFG_DATA_W'(chans) | (CFG_DATA_W'($urandom) & 11'h7f0));
    seg_eff = (segs > MAX_SEGMENTS) ? MAX_SEGMENTS : segs;
    ch_eff  = (chans > MAX_CHANNELS) ? MAX_CHANNELS : chans;
  endtask

  // read words drain at random, with one long hold-off on request
  initial begin : result_sink
    int r;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze_req) begin
        out_ch.ready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(negedge clk);
        squeeze_req = 1'b0;
      end else if (rx_calm) begin
        out_ch.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          out_ch.ready <= 1'b0;
          repeat ($urandom_range(10, 40)) @(negedge clk);
        end else begin
          out_ch.ready <= (r >= 30);
        end
      end
    end
  end

  initial begin : stimulus
    int read_pct;
    logic [CHAN_W-1:0] chan;
    tx_calm           = 1'b0;
    rx_calm           = 1'b0;
    squeeze_req       = 1'b0;
    seg_eff           = MAX_SEGMENTS;
    ch_eff            = MAX_CHANNELS;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.op          = OP_ACCUM;
    in_ch.pixel_label = '0;
    in_ch.channel     = '0;
    in_ch.grad_value  = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = REG_SUPERPIXEL_COUNT;
    cfg_ch.data       = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_counts(1024, 8);

    // directed: extremes, out-of-range labels, read-and-clear
    push_word(OP_ACCUM, 0, 0, 16'sh7fff);
    push_word(OP_ACCUM, 0, 0, 16'sh7fff);
    push_word(OP_READ,  0, 0, 0);
    push_word(OP_READ,  0, 0, 16'sh7fff);
    push_word(OP_ACCUM, 1023, 7, 16'sh8000);
    push_word(OP_ACCUM, 1023, 7, -16'sd1);
    push_word(OP_READ,  1023, 7, 0);
    push_word(OP_ACCUM, 1024, 0, 16'sd100);
    push_word(OP_READ,  1024, 0, 0);
    push_word(OP_ACCUM, -32'sd1, 3, 16'sd5);
    push_word(OP_ACCUM, 32'sh7fff_ffff, 3, 16'sd5);
    push_word(OP_ACCUM, 32'sh8000_0000, 3, 16'sd5);
    push_word(OP_READ,  -32'sd1, 3, 0);
    push_word(OP_READ,  32'sh8000_0000, 3, 0);
    push_word(OP_READ,  32'sh7fff_ffff, 3, 0);
    push_word(OP_ACCUM, 5, 2, 16'sd1);
    push_word(OP_ACCUM, 5, 2, 16'sh0000);
    push_word(OP_READ,  5, 2, 0);
    push_word(OP_READ,  5, 3, 0);
    end_burst();
    drain();

    for (int p = 0; p < PHASES; p++) begin
      set_counts(seg_set[p], ch_set[p]);
      if (p == 2) begin
        write_reg(REG_SPARE_A, CFG_DATA_W'($urandom));
        write_reg(REG_SPARE_B, CFG_DATA_W'($urandom));
      end
      tx_calm  = (p == CALM_PHASE);
      rx_calm  = (p == CALM_PHASE);
      read_pct = 30;
      if (p == SQUEEZE_PHASE) begin
        squeeze_req = 1'b1;
        read_pct    = 80;
      end
      repeat (PHASE_WORDS) begin
        if ($urandom_range(0, 1) == 0 || ch_eff == 0) chan = CHAN_W'($urandom);
        else chan = CHAN_W'($urandom_range(0, ch_eff - 1));
        push_word(($urandom_range(0, 99) < read_pct) ? OP_READ : OP_ACCUM,
                  pick_label(), chan, pick_grad());
      end
      end_burst();
      drain();
    end

    repeat (10) @(negedge clk);
    if (fail_count == 0 && pending_reads == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: label_scatter_accumulator_core.f
design/lsa_pkg.sv
design/lsa_in_if.sv
design/lsa_out_if.sv
design/lsa_cfg_if.sv
design/lsa_sum_ram.sv
design/lsa_cfg_regs.sv
design/lsa_accum.sv
design/label_scatter_accumulator_core.sv
tb/lsa_sum_checker.sv
tb/tb.sv
